>>> hw/rtl/pat_pkg.sv
// shared constants, codes, command/status structs and word conversion helpers
// for the positional array table; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pat_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;

  localparam int ACT_W  = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 6;
  localparam int ECNT_W = 7;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TRAVERSE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic capture;
    logic exec;
    logic emit;
  } pat_cmd_t;

  typedef struct packed {
    logic is_trav;
    logic empty;
    logic trav_last;
  } pat_sts_t;

  // sign-extend the request value, then keep the stored word width
  function automatic logic [DATA_WIDTH-1:0] to_word(logic signed [VAL_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // sign-extend a stored word and keep the output field width
  function automatic logic [VAL_W-1:0] from_word(logic [DATA_WIDTH-1:0] e);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]           w;
    s = signed'(e);
    w = 64'(s);
    return w[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pat_intf.sv
// request and response channel interfaces of the positional array table
// depends on pat_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface pat_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pat_pkg::ACT_W-1:0]     action;
  logic signed [pat_pkg::VAL_W-1:0]     value;
  logic        [pat_pkg::POS_W-1:0]     position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface pat_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pat_pkg::STAT_W-1:0]    status;
  logic        [pat_pkg::FIDX_W-1:0]    found_index;
  logic signed [pat_pkg::VAL_W-1:0]     entry_data;
  logic        [pat_pkg::ECNT_W-1:0]    entry_count;
  logic                                 last;

  modport source (output valid, status, found_index, entry_data, entry_count, last,
                  input ready);
  modport sink   (input valid, status, found_index, entry_data, entry_count, last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/positional_array_table_top.sv
// positional array table: insert, delete, search and traverse on an ordered word array
// insert, delete and search are captured in S_IDLE, and their result is registered in S_EXEC
// once the result register is free; traverse emits count entries from S_EXEC, one per cycle
// while that register is free; a new request is taken only in S_IDLE, also while a result waits
// reset clears the count and control; entry contents stay unknown until written
// depends on pat_pkg, pat_intf, pat_datapath and pat_ctrl
`timescale 1ns / 1ps
`default_nettype none

module positional_array_table_top (
  input wire logic clk,
  input wire logic rst,
  pat_req_if.sink  req,
  pat_rsp_if.source rsp
);

  pat_pkg::pat_cmd_t cmd;
  pat_pkg::pat_sts_t sts;

  pat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pat_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (req.action),
    .in_value        (req.value),
    .in_position     (req.position),
    .out_status      (rsp.status),
    .out_found_index (rsp.found_index),
    .out_entry_data  (rsp.entry_data),
    .out_entry_count (rsp.entry_count),
    .out_last        (rsp.last)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pat_datapath.sv
// entry register array, count, request capture, match vector and result register
// depends on pat_pkg; driven by pat_ctrl through pat_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module pat_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire pat_pkg::pat_cmd_t                    cmd,
  output pat_pkg::pat_sts_t                         sts,
  input  wire logic        [pat_pkg::ACT_W-1:0]     in_action,
  input  wire logic signed [pat_pkg::VAL_W-1:0]     in_value,
  input  wire logic        [pat_pkg::POS_W-1:0]     in_position,
  output logic             [pat_pkg::STAT_W-1:0]    out_status,
  output logic             [pat_pkg::FIDX_W-1:0]    out_found_index,
  output logic signed      [pat_pkg::VAL_W-1:0]     out_entry_data,
  output logic             [pat_pkg::ECNT_W-1:0]    out_entry_count,
  output logic                                      out_last
);

  logic [pat_pkg::DATA_WIDTH-1:0] ent [pat_pkg::CAPACITY];
  logic [pat_pkg::CNT_W-1:0]      cnt;
  logic [pat_pkg::ACT_W-1:0]      act;
  logic [pat_pkg::DATA_WIDTH-1:0] val;
  logic [pat_pkg::POS_W-1:0]      pos;
  logic [pat_pkg::CAPACITY-1:0]   hit;
  logic [pat_pkg::IDX_W-1:0]      tidx;

  logic [pat_pkg::DATA_WIDTH-1:0] in_word;
  logic [pat_pkg::ECNT_W-1:0]     cnt_x;
  logic [pat_pkg::ECNT_W-1:0]     pos_x;
  logic [pat_pkg::ECNT_W-1:0]     tidx_x;
  logic                           ins_bad;
  logic                           ins_ok;
  logic                           del_ok;
  logic                           is_full;
  logic                           any_hit;
  logic [pat_pkg::IDX_W-1:0]      fidx;
  logic [pat_pkg::ECNT_W-1:0]     cnt_new;
  logic [pat_pkg::STAT_W-1:0]     exec_status;

  assign in_word = pat_pkg::to_word(in_value);
  assign cnt_x   = pat_pkg::ECNT_W'(cnt);
  assign pos_x   = pat_pkg::ECNT_W'(pos);
  assign tidx_x  = pat_pkg::ECNT_W'(tidx);
  assign is_full = (cnt_x == pat_pkg::ECNT_W'(pat_pkg::CAPACITY));
  assign ins_bad = (pos_x > cnt_x);
  assign ins_ok  = !ins_bad && !is_full;
  assign del_ok  = (pos_x < cnt_x);
  assign any_hit = |hit;

  assign sts.is_trav   = (act == pat_pkg::ACT_TRAVERSE);
  assign sts.empty     = (cnt == '0);
  assign sts.trav_last = ((tidx_x + pat_pkg::ECNT_W'(1)) == cnt_x);

  // lowest matching index
  always_comb begin
    fidx = '0;
    for (int i = pat_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        fidx = pat_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    cnt_new     = cnt_x;
    exec_status = pat_pkg::ST_OK;
    unique case (act)
      pat_pkg::ACT_INSERT: begin
        if (ins_bad) begin
          exec_status = pat_pkg::ST_INVALID;
        end else if (is_full) begin
          exec_status = pat_pkg::ST_FULL;
        end else begin
          cnt_new = cnt_x + pat_pkg::ECNT_W'(1);
        end
      end
      pat_pkg::ACT_DELETE: begin
        if (!del_ok) begin
          exec_status = pat_pkg::ST_INVALID;
        end else begin
          cnt_new = cnt_x - pat_pkg::ECNT_W'(1);
        end
      end
      pat_pkg::ACT_SEARCH: begin
        exec_status = any_hit ? pat_pkg::ST_OK : pat_pkg::ST_NOT_FOUND;
      end
      pat_pkg::ACT_TRAVERSE: begin
        exec_status = pat_pkg::ST_EMPTY;
      end
      default: begin
        exec_status = pat_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec) begin
      cnt <= pat_pkg::CNT_W'(cnt_new);
    end
  end

  // entry array: shift up on insert, shift down on delete
  always_ff @(posedge clk) begin
    if (cmd.exec && act == pat_pkg::ACT_INSERT && ins_ok) begin
      for (int i = 0; i < pat_pkg::CAPACITY; i++) begin
        if (pat_pkg::ECNT_W'(i) == pos_x) begin
          ent[i] <= val;
        end else if (pat_pkg::ECNT_W'(i) > pos_x && pat_pkg::ECNT_W'(i) <= cnt_x) begin
          ent[i] <= ent[(i == 0) ? 0 : i - 1];
        end
      end
    end else if (cmd.exec && act == pat_pkg::ACT_DELETE && del_ok) begin
      for (int i = 0; i < pat_pkg::CAPACITY; i++) begin
        if (pat_pkg::ECNT_W'(i) >= pos_x && pat_pkg::ECNT_W'(i + 1) < cnt_x) begin
          ent[i] <= ent[(i == pat_pkg::CAPACITY - 1) ? i : i + 1];
        end
      end
    end
  end

  // request capture; the match vector is taken against the settled array
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= in_action;
      val  <= in_word;
      pos  <= in_position;
      tidx <= '0;
      for (int i = 0; i < pat_pkg::CAPACITY; i++) begin
        hit[i] <= (pat_pkg::ECNT_W'(i) < cnt_x) && (ent[i] == in_word);
      end
    end else if (cmd.emit) begin
      tidx <= tidx + pat_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status      <= exec_status;
      out_found_index <= (act == pat_pkg::ACT_SEARCH && any_hit) ?
                         pat_pkg::FIDX_W'(fidx) : '0;
      out_entry_data  <= '0;
      out_entry_count <= cnt_new;
      out_last        <= 1'b1;
    end else if (cmd.emit) begin
      out_status      <= pat_pkg::ST_OK;
      out_found_index <= '0;
      out_entry_data  <= pat_pkg::from_word(ent[tidx]);
      out_entry_count <= cnt_x;
      out_last        <= sts.trav_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= pat_pkg::ECNT_W'(pat_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && act == pat_pkg::ACT_INSERT && ins_ok) |=>
      cnt == pat_pkg::CNT_W'($past(cnt) + 1'b1))
    else $error("accepted insert did not grow the count");

  a_trav_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> tidx_x < cnt_x)
    else $error("traverse read past the stored entries");

endmodule

`default_nettype wire

>>> hw/rtl/pat_ctrl.sv
// request/response sequencing state machine of the positional array table
// depends on pat_pkg; commands pat_datapath through pat_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module pat_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire pat_pkg::pat_sts_t sts,
  output pat_pkg::pat_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;
  logic   trav_run;

  assign out_free    = !out_valid || out_ready;
  assign trav_run    = sts.is_trav && !sts.empty;
  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.exec    = (state == S_EXEC) && out_free && !trav_run;
  assign cmd.emit    = (state == S_EXEC) && out_free && trav_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec || cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.exec || (cmd.emit && sts.trav_last)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_emit_only_trav: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (sts.is_trav && !sts.empty))
    else $error("entry emitted outside a traverse");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.emit) |-> out_free)
    else $error("result register overwritten while held");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (state == S_IDLE && out_valid))
    else $error("single result request did not complete");

endmodule

`default_nettype wire

>>> test/positional_array_table_top_tb.sv
// self-checking testbench for positional_array_table_top: random and directed
// insert, delete, search and traverse requests, checked against a shadow table
// depends on pat_pkg, pat_intf and the rtl of positional_array_table_top
`timescale 1ns / 1ps

module positional_array_table_top_tb;

  localparam int RANDOM_ITEMS = 380;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 250;
  localparam int TAIL_ITEMS   = 40;

  typedef struct {
    logic        [pat_pkg::ACT_W-1:0] act;
    logic signed [pat_pkg::VAL_W-1:0] value;
    logic        [pat_pkg::POS_W-1:0] pos;
    bit                               wait_drain;
  } table_req_t;

  typedef struct packed {
    logic [pat_pkg::STAT_W-1:0] status;
    logic [pat_pkg::FIDX_W-1:0] found_index;
    logic [pat_pkg::VAL_W-1:0]  entry_data;
    logic [pat_pkg::ECNT_W-1:0] entry_count;
    logic                       last;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pat_req_if req_ch ();
  pat_rsp_if rsp_ch ();

  positional_array_table_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  table_req_t                     pending_reqs[$];
  table_rsp_t                     expected_rsps[$];
  logic [pat_pkg::DATA_WIDTH-1:0] shadow_words[pat_pkg::CAPACITY];
  int unsigned                    shadow_count = 0;
  bit                             failed = 1'b0;
  bit                             all_sent = 1'b0;
  bit                             tail_phase = 1'b0;
  int unsigned                    reqs_taken = 0;
  int unsigned                    cycles = 0;

  // ---------------------------------------------------------------------------
  // shadow table: applies one accepted request and queues the responses it owes
  // ---------------------------------------------------------------------------
  function void apply_table_request(logic [pat_pkg::ACT_W-1:0] act,
                                    logic signed [pat_pkg::VAL_W-1:0] val,
                                    logic [pat_pkg::POS_W-1:0] pos);
    logic signed [63:0]                    wide;
    logic [pat_pkg::DATA_WIDTH-1:0]        word;
    logic signed [pat_pkg::DATA_WIDTH-1:0] sword;
    table_rsp_t                            r;
    bit                                    hit;
    wide = val;
    word = wide[pat_pkg::DATA_WIDTH-1:0];
    r = '0;
    r.last = 1'b1;
    hit = 1'b0;
    case (act)
      pat_pkg::ACT_INSERT: begin
        // position check wins over the full check
        if (pos > shadow_count) begin
          r.status = pat_pkg::ST_INVALID;
        end else if (shadow_count >= pat_pkg::CAPACITY) begin
          r.status = pat_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = word;
          shadow_count++;
          r.status = pat_pkg::ST_OK;
        end
        r.entry_count = pat_pkg::ECNT_W'(shadow_count);
        expected_rsps.push_back(r);
      end
      pat_pkg::ACT_DELETE: begin
        if (pos >= shadow_count) begin
          r.status = pat_pkg::ST_INVALID;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
          r.status = pat_pkg::ST_OK;
        end
        r.entry_count = pat_pkg::ECNT_W'(shadow_count);
        expected_rsps.push_back(r);
      end
      pat_pkg::ACT_SEARCH: begin
        r.status = pat_pkg::ST_NOT_FOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_words[i] == word) begin
            hit = 1'b1;
            r.status = pat_pkg::ST_OK;
            r.found_index = pat_pkg::FIDX_W'(i);
          end
        end
        r.entry_count = pat_pkg::ECNT_W'(shadow_count);
        expected_rsps.push_back(r);
      end
      default: begin
        r.entry_count = pat_pkg::ECNT_W'(shadow_count);
        if (shadow_count == 0) begin
          r.status = pat_pkg::ST_EMPTY;
          expected_rsps.push_back(r);
        end else begin
          r.status = pat_pkg::ST_OK;
          for (int i = 0; i < shadow_count; i++) begin
            sword = shadow_words[i];
            wide = sword;
            r.entry_data = wide[pat_pkg::VAL_W-1:0];
            r.last = (i == shadow_count - 1);
            expected_rsps.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------
  int unsigned                      gen_count = 0;
  logic signed [pat_pkg::VAL_W-1:0] value_pool[$];

  task automatic queue_request(logic [pat_pkg::ACT_W-1:0] act,
                               logic signed [pat_pkg::VAL_W-1:0] val,
                               logic [pat_pkg::POS_W-1:0] pos, bit drain);
    table_req_t t;
    t.act = act;
    t.value = val;
    t.pos = pos;
    t.wait_drain = drain;
    pending_reqs.push_back(t);
    // track the count and recent inserted values, so that positions can be aimed at the live range
    if (act == pat_pkg::ACT_INSERT && pos <= gen_count && gen_count < pat_pkg::CAPACITY) begin
      gen_count++;
      value_pool.push_back(val);
      if (value_pool.size() > 48) void'(value_pool.pop_front());
    end else if (act == pat_pkg::ACT_DELETE && pos < gen_count) begin
      gen_count--;
    end
  endtask

  function automatic logic signed [pat_pkg::VAL_W-1:0] pick_value(int pool_pct);
    if (value_pool.size() > 0 && $urandom_range(0, 99) < pool_pct)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return pat_pkg::VAL_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                        phase_left;
    int                        ins_pct;
    int                        rr;
    logic [pat_pkg::ACT_W-1:0] act;
    logic [pat_pkg::POS_W-1:0] pos;
    req_ch.valid = 1'b0;
    req_ch.action = pat_pkg::ACT_INSERT;
    req_ch.value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;

    // directed part
    queue_request(pat_pkg::ACT_TRAVERSE, 32'sd0, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_DELETE, 32'sd0, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, 32'sd5, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, 32'sd9, 6'd1, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, 32'sh7fffffff, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, 32'sh80000000, 6'd1, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, 32'sd0, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, -32'sd1, 6'd3, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, 32'sd0, 6'd2, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, 32'sd0, 6'd63, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, -32'sd1, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, 32'sh80000000, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, 32'sd12345, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_TRAVERSE, 32'sd0, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_INSERT, 32'sd7, 6'd63, 1'b0);
    queue_request(pat_pkg::ACT_DELETE, 32'sd0, 6'd5, 1'b0);
    queue_request(pat_pkg::ACT_DELETE, 32'sd0, 6'd63, 1'b0);
    queue_request(pat_pkg::ACT_DELETE, 32'sd0, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, 32'sd0, 6'd0, 1'b0);
    queue_request(pat_pkg::ACT_DELETE, 32'sd0, 6'd3, 1'b0);
    queue_request(pat_pkg::ACT_DELETE, 32'sd0, 6'd1, 1'b0);
    queue_request(pat_pkg::ACT_TRAVERSE, -32'sd1, 6'd63, 1'b0);
    queue_request(pat_pkg::ACT_SEARCH, 32'sh7fffffff, 6'd0, 1'b1);

    // random part in phases that push the count up toward full, keep it level or push it down toward empty
    phase_left = 60;
    ins_pct = 90;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: ins_pct = 90;
          1: ins_pct = 50;
          default: ins_pct = 15;
        endcase
      end
      phase_left--;
      rr = $urandom_range(0, 99);
      pos = pat_pkg::POS_W'($urandom_range(0, 63));
      if (rr < 8) begin
        act = pat_pkg::ACT_TRAVERSE;
      end else if (rr < 28) begin
        act = pat_pkg::ACT_SEARCH;
      end else if ($urandom_range(0, 99) < ins_pct) begin
        act = pat_pkg::ACT_INSERT;
        rr = $urandom_range(0, 99);
        if (rr >= 20) pos = pat_pkg::POS_W'($urandom_range(0, gen_count));
        else if (rr >= 8) pos = pat_pkg::POS_W'(gen_count);
      end else begin
        act = pat_pkg::ACT_DELETE;
        if (gen_count > 0 && $urandom_range(0, 99) >= 10)
          pos = pat_pkg::POS_W'($urandom_range(0, gen_count - 1));
      end
      queue_request(act, pick_value(act == pat_pkg::ACT_SEARCH ? 60 : 15), pos, n == 200);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!(all_sent && expected_rsps.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d expected responses never arrived", expected_rsps.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  int unsigned tx_gap = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk) begin
    table_req_t nxt;
    if ($urandom_range(0, 149) == 0) tx_calm <= !tx_calm;
    if (rst) begin
      req_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
        all_sent <= 1'b1;
      end else if (pending_reqs[0].wait_drain && (req_ch.valid || expected_rsps.size() != 0)) begin
        // hold this request back until every owed response is out
        req_ch.valid <= 1'b0;
      end else if (!tail_phase && !tx_calm && $urandom_range(0, 99) < 20) begin
        tx_gap <= $urandom_range(1, 18) - 1;
        req_ch.valid <= 1'b0;
      end else begin
        nxt = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= nxt.act;
        req_ch.value <= nxt.value;
        req_ch.position <= nxt.pos;
      end
    end
    tail_phase <= (pending_reqs.size() < TAIL_ITEMS);
  end

  // ---------------------------------------------------------------------------
  // response ready: random stalls plus one long hold to back up the block
  // ---------------------------------------------------------------------------
  int unsigned rx_stall = 0;
  int unsigned long_hold = 0;
  bit          long_hold_done = 1'b0;
  bit          rx_calm = 1'b0;

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!long_hold_done && reqs_taken >= 100) begin
      long_hold_done <= 1'b1;
      long_hold <= LONG_HOLD;
      rsp_ch.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!tail_phase && !rx_calm && $urandom_range(0, 99) < 15) begin
      rx_stall <= $urandom_range(1, 18) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted request, checks each accepted response
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    table_rsp_t want;
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        apply_table_request(req_ch.action, req_ch.value, req_ch.position);
        reqs_taken <= reqs_taken + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request owing it: status %0d, entry_data 'h%0h",
                 rsp_ch.status, rsp_ch.entry_data);
          failed = 1'b1;
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", want.status, rsp_ch.status);
          check_field("found_index", want.found_index, rsp_ch.found_index);
          check_field("entry_data", want.entry_data, rsp_ch.entry_data);
          check_field("entry_count", want.entry_count, rsp_ch.entry_count);
          check_field("last", want.last, rsp_ch.last);
        end
      end
    end
  end

endmodule
